// ===== design/olst_pkg.sv =====
`timescale 1ns / 1ps
// Package with the shared constants, codes and types of the ordered list engine.
package olst_pkg;

  // Widths of the request and response fields.
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Default sizing of the list.
  localparam int DEF_DEPTH = 16;
  localparam int DEF_WIDTH = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_BACK   = 3'd0,
    MODE_ADD_FRONT  = 3'd1,
    MODE_INSERT     = 3'd2,
    MODE_TAKE_BACK  = 3'd3,
    MODE_TAKE_FRONT = 3'd4,
    MODE_READ       = 3'd5,
    MODE_REMOVE     = 3'd6
  } olst_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } olst_status_e;

  // Update command broadcast to every cell of the chain.
  typedef struct packed {
    logic open_gap;   // the target cell loads the new value; cells above it move one place toward the back
    logic close_gap;  // cells at and above the target take their back neighbor
    logic remove;     // cells from the first match on take their back neighbor
  } olst_ctl_t;

endpackage

// ===== design/olst_cmd_if.sv =====
`timescale 1ns / 1ps
// Request channel of the ordered list engine.
interface olst_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [olst_pkg::MODE_W-1:0]      mode;
  logic [olst_pkg::POS_W-1:0]       position;
  logic [olst_pkg::VALUE_W-1:0]     value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

// ===== design/olst_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel of the ordered list engine.
interface olst_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [olst_pkg::STATUS_W-1:0]    status;
  logic [olst_pkg::VALUE_W-1:0]     read_value;
  logic [olst_pkg::VALUE_W-1:0]     front_value;
  logic [olst_pkg::VALUE_W-1:0]     back_value;
  logic [olst_pkg::COUNT_W-1:0]     entry_count;
  logic                             is_empty;

  modport source (output valid, status, read_value, front_value, back_value,
                  entry_count, is_empty, input ready);
  modport sink   (input valid, status, read_value, front_value, back_value,
                  entry_count, is_empty, output ready);
endinterface

// ===== design/olst_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list chain, with its shift, match and gather logic.
module olst_cell #(
  parameter int WIDTH = olst_pkg::DEF_WIDTH,
  parameter int CW    = 5,
  parameter int INDEX = 0
) (
  input  logic                clk_i,
  input  olst_pkg::olst_ctl_t ctl_i,
  input  logic [CW-1:0]       at_i,
  input  logic [CW-1:0]       count_i,
  input  logic [WIDTH-1:0]    val_i,
  input  logic [WIDTH-1:0]    prev_i,
  input  logic [WIDTH-1:0]    next_i,
  input  logic                seen_i,
  input  logic [CW-1:0]       rd_idx_i,
  input  logic [CW-1:0]       bk_idx_i,
  input  logic [WIDTH-1:0]    rd_i,
  input  logic [WIDTH-1:0]    bk_i,
  output logic [WIDTH-1:0]    q_o,
  output logic                seen_o,
  output logic [WIDTH-1:0]    rd_o,
  output logic [WIDTH-1:0]    bk_o
);

  localparam logic [CW-1:0] ME = CW'(INDEX);

  logic [WIDTH-1:0] val_q;
  logic [WIDTH-1:0] val_d;
  logic             live;
  logic             match;

  // The match chain runs every cycle; only a remove command lets it move cells.
  assign live   = ME < count_i;
  assign match  = live && (val_q == val_i);
  assign seen_o = seen_i | match;

  always_comb begin
    val_d = val_q;
    if (ctl_i.open_gap) begin
      if (ME == at_i) begin
        val_d = val_i;
      end else if (ME > at_i) begin
        val_d = prev_i;
      end
    end
    if ((ctl_i.close_gap && (ME >= at_i)) || (ctl_i.remove && seen_o)) begin
      val_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // Each cell adds its value to the read and back buses when it is selected.
  assign rd_o = rd_i | ((rd_idx_i == ME) ? val_q : '0);
  assign bk_o = bk_i | ((bk_idx_i == ME) ? val_q : '0);
  assign q_o  = val_q;

endmodule

// ===== design/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// Top level of the ordered list engine: command decode, cell chain and response register.
//
//   Channel   Direction  Carries
//   cmd_i     in         mode, position, value
//   rsp_o     out        status, read_value, front_value, back_value, entry_count, is_empty
//
// A request has a decode step and a gather step. In the cycle it is accepted, the command is
// decoded against the fill count and broadcast to the cell chain, and every
// cell shifts, loads or holds at the next edge. In the gather step the front,
// back and read values are gathered from the updated cells into the response
// register. The gather cycle waits while an earlier response is still held,
// and a new request is taken once the gather cycle is done, so one request
// can be stored in the cells while the previous response waits on rsp_o.
// Reset clears the fill count and the handshake state; the cell contents are
// left undefined and are never shown before they are written.
module ordered_list_engine #(
  parameter int DEPTH = olst_pkg::DEF_DEPTH,
  parameter int WIDTH = olst_pkg::DEF_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  olst_cmd_if.sink   cmd_i,
  olst_rsp_if.source rsp_o
);

  // Count width holds DEPTH itself; compare width also covers the position field.
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;

  // Fill count and the request waiting for its gather cycle.
  logic [CW-1:0]                 count_q, count_d;
  logic                          busy_q;
  logic [olst_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          rd_en_q, rd_en_d;
  logic [CW-1:0]                 rd_idx_q;

  // Response register.
  logic                          out_valid_q;
  logic [olst_pkg::STATUS_W-1:0] out_status_q;
  logic [olst_pkg::VALUE_W-1:0]  out_rd_q;
  logic [olst_pkg::VALUE_W-1:0]  out_front_q;
  logic [olst_pkg::VALUE_W-1:0]  out_back_q;
  logic [CW-1:0]                 out_count_q;

  logic                          accept;
  logic                          gather;
  logic                          full;
  logic                          empty;
  logic [CMPW-1:0]               pos_w;
  logic [CMPW-1:0]               cnt_w;
  logic [CW-1:0]                 at;
  logic [WIDTH-1:0]              wr_val;
  olst_pkg::olst_ctl_t           ctl;
  olst_pkg::olst_ctl_t           ctl_en;
  logic                          found;

  // Chain wiring between neighboring cells.
  logic [WIDTH-1:0] q_w   [DEPTH];
  logic [WIDTH-1:0] prev_w[DEPTH];
  logic [WIDTH-1:0] next_w[DEPTH];
  logic             seen_w[DEPTH+1];
  logic [WIDTH-1:0] rd_w  [DEPTH+1];
  logic [WIDTH-1:0] bk_w  [DEPTH+1];
  logic [CW-1:0]    bk_idx;

  assign accept = cmd_i.valid && cmd_i.ready;
  assign gather = busy_q && (!out_valid_q || rsp_o.ready);
  assign cmd_i.ready = !busy_q;

  assign full   = count_q == CW'(DEPTH);
  assign empty  = count_q == '0;
  assign pos_w  = CMPW'(cmd_i.position);
  assign cnt_w  = CMPW'(count_q);
  assign wr_val = WIDTH'(cmd_i.value);
  assign found  = seen_w[DEPTH];

  // Decode the request against the current fill count.
  always_comb begin
    status_d = olst_pkg::ST_OK;
    rd_en_d  = 1'b0;
    count_d  = count_q;
    at       = '0;
    ctl      = '0;
    case (olst_pkg::olst_mode_e'(cmd_i.mode))
      olst_pkg::MODE_ADD_BACK, olst_pkg::MODE_ADD_FRONT, olst_pkg::MODE_INSERT: begin
        if (cmd_i.mode == olst_pkg::MODE_ADD_BACK) begin
          at = count_q;
        end else if (cmd_i.mode == olst_pkg::MODE_INSERT) begin
          at = CW'(cmd_i.position);
        end
        if (full) begin
          status_d = olst_pkg::ST_FULL;
        end else if ((cmd_i.mode == olst_pkg::MODE_INSERT) && (pos_w > cnt_w)) begin
          status_d = olst_pkg::ST_RANGE;
        end else begin
          ctl.open_gap = 1'b1;
          count_d      = count_q + 1'b1;
        end
      end
      olst_pkg::MODE_TAKE_BACK: begin
        if (empty) begin
          status_d = olst_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      olst_pkg::MODE_TAKE_FRONT: begin
        if (empty) begin
          status_d = olst_pkg::ST_EMPTY;
        end else begin
          ctl.close_gap = 1'b1;
          count_d       = count_q - 1'b1;
        end
      end
      olst_pkg::MODE_READ: begin
        if (empty) begin
          status_d = olst_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_d = olst_pkg::ST_RANGE;
        end else begin
          rd_en_d = 1'b1;
        end
      end
      olst_pkg::MODE_REMOVE: begin
        // The chain finds the first match; with none, no cell moves.
        if (empty) begin
          status_d = olst_pkg::ST_EMPTY;
        end else begin
          ctl.remove = 1'b1;
          if (found) begin
            count_d = count_q - 1'b1;
          end else begin
            status_d = olst_pkg::ST_RANGE;
          end
        end
      end
      default: begin
        status_d = olst_pkg::ST_RANGE;
      end
    endcase
  end

  // Cells only move in the cycle a request is accepted.
  assign ctl_en = accept ? ctl : '0;

  // Index of the back value in the updated list; unused when the list is empty.
  assign bk_idx = count_q - 1'b1;

  assign seen_w[0] = 1'b0;
  assign rd_w[0]   = '0;
  assign bk_w[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_w[i] = '0;
    end else begin : g_mid
      assign prev_w[i] = q_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w[i] = '0;
    end else begin : g_inner
      assign next_w[i] = q_w[i+1];
    end

    olst_cell #(
      .WIDTH (WIDTH),
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl_en),
      .at_i     (at),
      .count_i  (count_q),
      .val_i    (wr_val),
      .prev_i   (prev_w[i]),
      .next_i   (next_w[i]),
      .seen_i   (seen_w[i]),
      .rd_idx_i (rd_idx_q),
      .bk_idx_i (bk_idx),
      .rd_i     (rd_w[i]),
      .bk_i     (bk_w[i]),
      .q_o      (q_w[i]),
      .seen_o   (seen_w[i+1]),
      .rd_o     (rd_w[i+1]),
      .bk_o     (bk_w[i+1])
    );
  end

  // Control state: fill count, pending request and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        busy_q  <= 1'b1;
      end else if (gather) begin
        busy_q  <= 1'b0;
      end
      if (gather) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the pending request and of the response register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_en_q  <= rd_en_d;
      rd_idx_q <= CW'(cmd_i.position);
    end
    if (gather) begin
      out_status_q <= status_q;
      out_rd_q     <= rd_en_q ? olst_pkg::VALUE_W'(rd_w[DEPTH]) : '0;
      out_front_q  <= empty ? '0 : olst_pkg::VALUE_W'(q_w[0]);
      out_back_q   <= empty ? '0 : olst_pkg::VALUE_W'(bk_w[DEPTH]);
      out_count_q  <= count_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.read_value  = out_rd_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.back_value  = out_back_q;
  assign rsp_o.entry_count = olst_pkg::COUNT_W'(out_count_q);
  assign rsp_o.is_empty    = out_count_q == '0;

endmodule
